// ===== rtl/cspm_pkg.sv =====
// package for the connection string password masker
// parse state type, mode codes and the constant text tables
// no dependencies
package cspm_pkg;

	typedef enum logic [1:0] {
		MODE_KEY    = 2'd0,
		MODE_VSTART = 2'd1,
		MODE_PLAIN  = 2'd2,
		MODE_BRACE  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic       redact;
		logic [3:0] key_cnt;
		logic       may_pwd;
		logic       may_password;
		logic       key_begun;
		logic       space_after;
	} parse_state_t;

	localparam logic [3:0] KEY_SAT   = 4'd9;
	localparam logic [3:0] LEN_PWD   = 4'd3;
	localparam logic [3:0] LEN_PASSW = 4'd8;
	localparam logic [3:0] MASK_LEN  = 4'd8;

	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam parse_state_t PARSE_RESET = '{
		mode:         MODE_KEY,
		redact:       1'b0,
		key_cnt:      4'd0,
		may_pwd:      1'b1,
		may_password: 1'b1,
		key_begun:    1'b0,
		space_after:  1'b0
	};

	// text "<masked>"
	function automatic logic [7:0] mask_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h3C;
			3'd1: c = 8'h6D;
			3'd2: c = 8'h61;
			3'd3: c = 8'h73;
			3'd4: c = 8'h6B;
			3'd5: c = 8'h65;
			3'd6: c = 8'h64;
			3'd7: c = 8'h3E;
			default: c = 8'h3E;
		endcase
		return c;
	endfunction

	// text "PWD"
	function automatic logic [7:0] pwd_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h50;
			2'd1: c = 8'h57;
			2'd2: c = 8'h44;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// text "PASSWORD"
	function automatic logic [7:0] password_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h50;
			3'd1: c = 8'h41;
			3'd2: c = 8'h53;
			3'd3: c = 8'h53;
			3'd4: c = 8'h57;
			3'd5: c = 8'h4F;
			3'd6: c = 8'h52;
			3'd7: c = 8'h44;
			default: c = 8'h44;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/conn_string_password_masker.sv =====
// Connection string password masker.
// Channels: src (in_byte, in_last) and dst (out_byte, out_valid, out_last),
// each with a valid and a stall; a transaction completes on a clock edge
// with valid high and stall low.
// A byte is registered on input, parsed from the input register and the
// result lands in the output register. Throughput is one byte per cycle
// unless dst stalls or a mask burst runs. An '=' that ends a PWD or
// PASSWORD key produces nine transactions ('=' then "<masked>"); the output
// register sends them one per cycle unless dst stalls; the input stage waits.
// Bytes inside a masked value produce no transaction; a masked byte flagged
// last produces an empty marker (out_valid low, out_last high).
// When dst stalls with the output register full, that register holds, the
// input register takes at most one more transaction and src_stall is high
// for as long as the input register stays full; no transaction is dropped.
// Reset (arst_n low) empties both registers and returns the parser to key
// mode; parser state also returns to reset after every last byte.
// Depends on cspm_pkg and cspm_parse.
module conn_string_password_masker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	cspm_pkg::parse_state_t state_q;
	cspm_pkg::parse_state_t state_next;

	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       ochar_q;
	logic       olast_q;
	logic [3:0] mask_cnt_q;
	logic       mask_last_q;

	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_char;
	logic       emit_last;
	logic       mask_go;
	logic       out_free;
	logic       adv_s1;
	logic       src_take;
	logic [2:0] mask_idx;

	cspm_parse u_parse (
		.st        (state_q),
		.byte_in   (byte_s1),
		.last_in   (last_s1),
		.st_next   (state_next),
		.emit      (emit),
		.emit_byte (emit_byte),
		.emit_char (emit_char),
		.emit_last (emit_last),
		.mask_go   (mask_go)
	);

	assign out_free  = !ovalid_q || !dst_stall;
	assign adv_s1    = valid_s1 && (mask_cnt_q == 4'd0) && out_free;
	assign src_stall = valid_s1 && !adv_s1;
	assign src_take  = src_valid && !src_stall;
	assign mask_idx  = 3'(cspm_pkg::MASK_LEN - mask_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= cspm_pkg::PARSE_RESET;
		end else begin
			if (src_take)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q    <= 1'b0;
			mask_cnt_q  <= 4'd0;
			mask_last_q <= 1'b0;
		end else begin
			if (mask_cnt_q != 4'd0 && out_free) begin
				ovalid_q   <= 1'b1;
				mask_cnt_q <= mask_cnt_q - 4'd1;
			end else if (adv_s1) begin
				ovalid_q    <= emit;
				mask_cnt_q  <= mask_go ? cspm_pkg::MASK_LEN : 4'd0;
				mask_last_q <= last_s1;
			end else if (!dst_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mask_cnt_q != 4'd0 && out_free) begin
			obyte_q <= cspm_pkg::mask_char(mask_idx);
			ochar_q <= 1'b1;
			olast_q <= mask_last_q && (mask_cnt_q == 4'd1);
		end else if (adv_s1) begin
			obyte_q <= emit_byte;
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign dst_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign out_valid = ochar_q;
	assign out_last  = olast_q;

	// a pending mask burst always sits behind a full output register
	a_burst_full: assert property (@(posedge clk) disable iff (!arst_n)
		mask_cnt_q != 4'd0 |-> ovalid_q)
		else $error("mask burst pending with empty output register");

	// the burst never exceeds the mask length
	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		mask_cnt_q <= cspm_pkg::MASK_LEN)
		else $error("mask counter out of range");

	// an empty marker only ever ends a string
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !out_valid |-> out_last && out_byte == 8'h00)
		else $error("empty marker without last");

	// a held input byte stays held while the burst runs
	a_burst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mask_cnt_q != 4'd0 |-> src_stall)
		else $error("input advanced during mask burst");

endmodule

// ===== rtl/cspm_parse.sv =====
// one-byte step of the key/value parser: next state and the first result
// of the byte, plus whether the mask burst follows
// depends on cspm_pkg
module cspm_parse (
	input  cspm_pkg::parse_state_t st,
	input  logic [7:0]             byte_in,
	input  logic                   last_in,
	output cspm_pkg::parse_state_t st_next,
	output logic                   emit,
	output logic [7:0]             emit_byte,
	output logic                   emit_char,
	output logic                   emit_last,
	output logic                   mask_go
);

	logic                   blank;
	logic [7:0]             upper;
	logic                   hit;
	logic                   put;
	cspm_pkg::parse_state_t nx;
	cspm_pkg::parse_state_t kc;

	always_comb begin
		blank = (byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0A) ||
			(byte_in == 8'h0B) || (byte_in == 8'h0C) || (byte_in == 8'h0D);
		upper = (byte_in >= 8'h61 && byte_in <= 8'h7A) ? byte_in - 8'h20 : byte_in;
		hit = st.key_begun &&
			((st.may_pwd && st.key_cnt == cspm_pkg::LEN_PWD) ||
			 (st.may_password && st.key_cnt == cspm_pkg::LEN_PASSW));
	end

	// key character update
	always_comb begin
		kc = st;
		if (blank) begin
			if (st.key_begun)
				kc.space_after = 1'b1;
		end else begin
			if (st.space_after) begin
				kc.may_pwd      = 1'b0;
				kc.may_password = 1'b0;
			end
			kc.key_begun = 1'b1;
			if (st.key_cnt < cspm_pkg::LEN_PWD) begin
				if (cspm_pkg::pwd_char(st.key_cnt[1:0]) != upper)
					kc.may_pwd = 1'b0;
			end else begin
				kc.may_pwd = 1'b0;
			end
			if (st.key_cnt < cspm_pkg::LEN_PASSW) begin
				if (cspm_pkg::password_char(st.key_cnt[2:0]) != upper)
					kc.may_password = 1'b0;
			end else begin
				kc.may_password = 1'b0;
			end
			if (st.key_cnt < cspm_pkg::KEY_SAT)
				kc.key_cnt = st.key_cnt + 4'd1;
		end
	end

	always_comb begin
		nx      = st;
		put     = 1'b1;
		mask_go = 1'b0;
		case (st.mode)
			cspm_pkg::MODE_KEY: begin
				if (byte_in == cspm_pkg::CH_EQ) begin
					mask_go   = hit;
					nx.redact = hit;
					nx.mode   = cspm_pkg::MODE_VSTART;
				end else if (byte_in == cspm_pkg::CH_SEMI) begin
					nx = cspm_pkg::PARSE_RESET;
				end else begin
					nx = kc;
				end
			end
			cspm_pkg::MODE_VSTART, cspm_pkg::MODE_PLAIN: begin
				if (byte_in == cspm_pkg::CH_SEMI) begin
					nx = cspm_pkg::PARSE_RESET;
				end else begin
					put = !st.redact;
					if (st.mode == cspm_pkg::MODE_VSTART && byte_in == cspm_pkg::CH_LBRACE)
						nx.mode = cspm_pkg::MODE_BRACE;
					else
						nx.mode = cspm_pkg::MODE_PLAIN;
				end
			end
			default: begin
				put = !st.redact;
				if (byte_in == cspm_pkg::CH_RBRACE)
					nx = cspm_pkg::PARSE_RESET;
			end
		endcase
		if (last_in)
			nx = cspm_pkg::PARSE_RESET;
	end

	assign st_next   = nx;
	assign emit      = put || last_in;
	assign emit_byte = put ? byte_in : 8'h00;
	assign emit_char = put;
	// with a mask burst the last flag moves to the final mask byte
	assign emit_last = last_in && !mask_go;

endmodule
